// File: design/pea_pkg.sv
// ----------------------------------------------------------------------------
// pea_pkg: shared types and constants for the page extent allocator
// Beat formats, command and status codes, table entry layout, FSM states.
// ----------------------------------------------------------------------------
`default_nettype none

package pea_pkg;

  localparam int unsigned PAGE_BITS = 20;
  localparam int unsigned LEN_BITS  = 21;
  localparam int unsigned STAT_BITS = 2;

  // Command codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // Status codes
  localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_SHORT = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_BAD   = 2'd2;
  localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic                 cmd;
    logic [PAGE_BITS-1:0] base_page;
    logic [LEN_BITS-1:0]  page_count;
  } in_beat_t;

  typedef struct packed {
    logic [STAT_BITS-1:0] status;
    logic [PAGE_BITS-1:0] extent_base;
    logic [LEN_BITS-1:0]  extent_pages;
    logic                 last;
  } out_beat_t;

  // One free extent as stored in the table
  typedef struct packed {
    logic [PAGE_BITS-1:0] start;
    logic [LEN_BITS-1:0]  len;
  } extent_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_ADD_DEC,
    S_SHU_RD,
    S_SHU_WR,
    S_INS_WR,
    S_SHD_RD,
    S_SHD_WR,
    S_SHD_END,
    S_AL_RD,
    S_AL_CHK,
    S_FIN
  } state_e;

endpackage

`default_nettype wire

// File: design/page_extent_allocator.sv
// ----------------------------------------------------------------------------
// page_extent_allocator: address-ordered free extent table with coalescing
// Adds merge free extents with their neighbors; allocates take extents from
// the lowest page upward and split the last one if it is larger than needed.
// ----------------------------------------------------------------------------
// The free extents live in one single-port table with a registered read,
// sorted by base page, and each command that passes its checks walks it entry
// by entry. An add scans up to its insertion point, then shifts the tail up
// for a fresh entry or down after a three-way merge. An allocate emits one
// beat per extent taken, then compacts the table by moving the remaining
// entries down. A new command is taken only once the previous one has
// finished. Each result beat waits in the output register until taken, and
// the next beat of a command (including the closing beat of an add) stalls
// until that register is free.
`default_nettype none

module page_extent_allocator #(
  parameter int unsigned MAX_EXTENTS = 64
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire pea_pkg::in_beat_t   in_data_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output pea_pkg::out_beat_t       out_data_o
);

  localparam int unsigned IDX_W = $clog2(MAX_EXTENTS);
  localparam int unsigned CNT_W = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned SUM_W = pea_pkg::LEN_BITS + 1;
  localparam logic [SUM_W-1:0] PAGE_SPACE = SUM_W'(1) << pea_pkg::PAGE_BITS;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_EXTENTS);

  // Table storage
  pea_pkg::extent_t mem_q [MAX_EXTENTS];
  pea_pkg::extent_t rd_q;

  pea_pkg::state_e state_q, state_d;

  logic                          cmd_q;
  logic [pea_pkg::PAGE_BITS-1:0] b_q;
  logic [pea_pkg::LEN_BITS-1:0]  n_q, need_q;
  logic [CNT_W-1:0]              pos_q, used_q, sh_q, cnt_q;
  pea_pkg::extent_t              prev_q;
  logic                          prev_v_q;
  logic [pea_pkg::LEN_BITS-1:0]  total_q;
  logic [pea_pkg::STAT_BITS-1:0] st_q;
  logic                          ov_q;
  pea_pkg::out_beat_t            out_q;

  logic                          slot_free;
  logic                          in_acc;
  logic                          rd_en, wr_en;
  logic [IDX_W-1:0]              rd_addr, wr_addr;
  pea_pkg::extent_t              wr_data;
  logic                          emit;
  pea_pkg::out_beat_t            emit_beat;

  // Add decision terms
  logic [SUM_W-1:0] prev_end, b_end, in_end;
  logic             nx_v, add_bad, mp, mn;
  logic             al_whole;
  logic [pea_pkg::LEN_BITS-1:0] need_rem;
  logic [CNT_W-1:0] taken_nx;

  assign slot_free = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == pea_pkg::S_IDLE);
  assign in_acc = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign out_data_o = out_q;

  assign in_end   = SUM_W'(in_data_i.base_page) + SUM_W'(in_data_i.page_count);
  assign prev_end = SUM_W'(prev_q.start) + SUM_W'(prev_q.len);
  assign b_end    = SUM_W'(b_q) + SUM_W'(n_q);
  assign nx_v     = pos_q < used_q;
  assign add_bad  = (prev_v_q && prev_end > SUM_W'(b_q)) ||
                    (nx_v && b_end > SUM_W'(rd_q.start));
  assign mp       = prev_v_q && prev_end == SUM_W'(b_q);
  assign mn       = nx_v && b_end == SUM_W'(rd_q.start);
  assign al_whole = rd_q.len <= need_q;
  assign need_rem = need_q - rd_q.len;
  assign taken_nx = cnt_q + CNT_W'(al_whole);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pea_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.cmd == pea_pkg::CMD_ADD) begin
            if (in_data_i.page_count == '0 || in_end > PAGE_SPACE) state_d = pea_pkg::S_FIN;
            else if (used_q == '0) state_d = pea_pkg::S_ADD_DEC;
            else state_d = pea_pkg::S_SCAN_RD;
          end else begin
            if (in_data_i.page_count == '0 || in_data_i.page_count > total_q) begin
              state_d = pea_pkg::S_FIN;
            end else begin
              state_d = pea_pkg::S_AL_RD;
            end
          end
        end
      end
      pea_pkg::S_SCAN_RD: state_d = pea_pkg::S_SCAN_CHK;
      pea_pkg::S_SCAN_CHK: begin
        if (rd_q.start < b_q && CNT_W'(pos_q + 1'b1) < used_q) state_d = pea_pkg::S_SCAN_RD;
        else state_d = pea_pkg::S_ADD_DEC;
      end
      pea_pkg::S_ADD_DEC: begin
        if (add_bad) state_d = pea_pkg::S_FIN;
        else if (mp && mn) begin
          if (CNT_W'(pos_q + 1'b1) < used_q) state_d = pea_pkg::S_SHD_RD;
          else state_d = pea_pkg::S_SHD_END;
        end else if (mp || mn) state_d = pea_pkg::S_FIN;
        else if (used_q == FULL_CNT) state_d = pea_pkg::S_FIN;
        else if (used_q > pos_q) state_d = pea_pkg::S_SHU_RD;
        else state_d = pea_pkg::S_INS_WR;
      end
      pea_pkg::S_SHU_RD: state_d = pea_pkg::S_SHU_WR;
      pea_pkg::S_SHU_WR: begin
        if (CNT_W'(sh_q - 1'b1) == pos_q) state_d = pea_pkg::S_INS_WR;
        else state_d = pea_pkg::S_SHU_RD;
      end
      pea_pkg::S_INS_WR: state_d = pea_pkg::S_FIN;
      pea_pkg::S_SHD_RD: state_d = pea_pkg::S_SHD_WR;
      pea_pkg::S_SHD_WR: begin
        if (CNT_W'(sh_q + 1'b1 + cnt_q) < used_q) state_d = pea_pkg::S_SHD_RD;
        else state_d = pea_pkg::S_SHD_END;
      end
      pea_pkg::S_SHD_END: begin
        if (cmd_q == pea_pkg::CMD_ADD) state_d = pea_pkg::S_FIN;
        else state_d = pea_pkg::S_IDLE;
      end
      pea_pkg::S_AL_RD: state_d = pea_pkg::S_AL_CHK;
      pea_pkg::S_AL_CHK: begin
        if (slot_free) begin
          if (al_whole && need_rem != '0) state_d = pea_pkg::S_AL_RD;
          else if (taken_nx != '0 && taken_nx < used_q) state_d = pea_pkg::S_SHD_RD;
          else state_d = pea_pkg::S_SHD_END;
        end
      end
      pea_pkg::S_FIN: begin
        if (slot_free) state_d = pea_pkg::S_IDLE;
      end
      default: state_d = pea_pkg::S_IDLE;
    endcase
  end

  // Table port and result beat
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = rd_q;
    emit      = 1'b0;
    emit_beat = '0;
    unique case (state_q)
      pea_pkg::S_SCAN_RD, pea_pkg::S_AL_RD: begin
        rd_en   = 1'b1;
        rd_addr = pos_q[IDX_W-1:0];
      end
      pea_pkg::S_ADD_DEC: begin
        if (!add_bad && mp) begin
          wr_en   = 1'b1;
          wr_addr = IDX_W'(pos_q - 1'b1);
          wr_data.start = prev_q.start;
          wr_data.len   = prev_q.len + n_q + (mn ? rd_q.len : '0);
        end else if (!add_bad && mn) begin
          wr_en   = 1'b1;
          wr_addr = pos_q[IDX_W-1:0];
          wr_data.start = b_q;
          wr_data.len   = rd_q.len + n_q;
        end
      end
      pea_pkg::S_SHU_RD: begin
        rd_en   = 1'b1;
        rd_addr = IDX_W'(sh_q - 1'b1);
      end
      pea_pkg::S_SHU_WR, pea_pkg::S_SHD_WR: begin
        wr_en   = 1'b1;
        wr_addr = sh_q[IDX_W-1:0];
        wr_data = rd_q;
      end
      pea_pkg::S_INS_WR: begin
        wr_en   = 1'b1;
        wr_addr = pos_q[IDX_W-1:0];
        wr_data.start = b_q;
        wr_data.len   = n_q;
      end
      pea_pkg::S_SHD_RD: begin
        rd_en   = 1'b1;
        rd_addr = IDX_W'(sh_q + cnt_q);
      end
      pea_pkg::S_AL_CHK: begin
        if (slot_free) begin
          emit = 1'b1;
          emit_beat.status      = pea_pkg::ST_OK;
          emit_beat.extent_base = rd_q.start;
          if (al_whole) begin
            emit_beat.extent_pages = rd_q.len;
            emit_beat.last         = (need_rem == '0);
          end else begin
            emit_beat.extent_pages = need_q;
            emit_beat.last         = 1'b1;
            wr_en   = 1'b1;
            wr_addr = pos_q[IDX_W-1:0];
            wr_data.start = rd_q.start + need_q[pea_pkg::PAGE_BITS-1:0];
            wr_data.len   = rd_q.len - need_q;
          end
        end
      end
      pea_pkg::S_FIN: begin
        if (slot_free) begin
          emit = 1'b1;
          emit_beat.status = st_q;
          emit_beat.last   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Memory: synchronous write, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  // Control and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pea_pkg::S_IDLE;
      used_q  <= '0;
      total_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      unique case (state_q)
        pea_pkg::S_ADD_DEC: begin
          if (!add_bad && (mp || mn)) total_q <= total_q + n_q;
        end
        pea_pkg::S_INS_WR: begin
          used_q  <= CNT_W'(used_q + 1'b1);
          total_q <= total_q + n_q;
        end
        pea_pkg::S_SHD_END: used_q <= used_q - cnt_q;
        pea_pkg::S_AL_CHK: begin
          if (slot_free && !(al_whole && need_rem != '0)) total_q <= total_q - n_q;
        end
        default: ;
      endcase
    end
  end

  // Command datapath
  always_ff @(posedge clk_i) begin
    if (emit) out_q <= emit_beat;
    unique case (state_q)
      pea_pkg::S_IDLE: begin
        cmd_q    <= in_data_i.cmd;
        b_q      <= in_data_i.base_page;
        n_q      <= in_data_i.page_count;
        need_q   <= in_data_i.page_count;
        pos_q    <= '0;
        prev_v_q <= 1'b0;
        cnt_q    <= '0;
        if (in_data_i.cmd == pea_pkg::CMD_ADD) st_q <= pea_pkg::ST_BAD;
        else if (in_data_i.page_count == '0) st_q <= pea_pkg::ST_BAD;
        else st_q <= pea_pkg::ST_SHORT;
      end
      pea_pkg::S_SCAN_CHK: begin
        if (rd_q.start < b_q) begin
          prev_q   <= rd_q;
          prev_v_q <= 1'b1;
          pos_q    <= CNT_W'(pos_q + 1'b1);
        end
      end
      pea_pkg::S_ADD_DEC: begin
        if (add_bad) st_q <= pea_pkg::ST_BAD;
        else if (!mp && !mn && used_q == FULL_CNT) st_q <= pea_pkg::ST_FULL;
        else st_q <= pea_pkg::ST_OK;
        sh_q  <= (mp && mn) ? pos_q : used_q;
        cnt_q <= CNT_W'(1);
      end
      pea_pkg::S_SHU_WR: sh_q <= CNT_W'(sh_q - 1'b1);
      pea_pkg::S_SHD_WR: sh_q <= CNT_W'(sh_q + 1'b1);
      pea_pkg::S_AL_CHK: begin
        if (slot_free) begin
          need_q <= al_whole ? need_rem : '0;
          pos_q  <= CNT_W'(pos_q + 1'b1);
          cnt_q  <= taken_nx;
          sh_q   <= '0;
        end
      end
      default: ;
    endcase
  end

  // Checks
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= FULL_CNT) else $error("extent count above table depth");

  // Total and count settle together once a command is done
  a_total_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pea_pkg::S_IDLE) |-> ((total_q == '0) == (used_q == '0)))
    else $error("free total and count disagree");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != pea_pkg::S_IDLE) else $error("command dropped");

  a_no_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> state_q != pea_pkg::S_IDLE) else $error("beat emitted while idle");

endmodule

`default_nettype wire
